### design/scfe_pkg.sv
package scfe_pkg;

  // Default ring depth
  localparam int RING_DEPTH_DEF = 256;

  // Command codes
  localparam logic [1:0] CMD_ENQ   = 2'd0;
  localparam logic [1:0] CMD_TXRDY = 2'd1;
  localparam logic [1:0] CMD_RX    = 2'd2;
  localparam logic [1:0] CMD_LS    = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_TX      = 2'd1;
  localparam logic [1:0] KIND_CONSOLE = 2'd2;
  localparam logic [1:0] KIND_SYSRQ   = 2'd3;

  // Flow control characters
  localparam logic [7:0] CODE_XOFF = 8'h13;
  localparam logic [7:0] CODE_XON  = 8'h11;

  // Line status masks
  localparam logic [7:0] LS_DATA    = 8'h01;
  localparam logic [7:0] LS_OVERRUN = 8'h02;
  localparam logic [7:0] LS_PARITY  = 8'h04;
  localparam logic [7:0] LS_FRAMING = 8'h08;
  localparam logic [7:0] LS_BREAK   = 8'h10;

  // Classified request handed from front to back
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
    logic       is_xoff;
    logic       is_xon;
    logic       tx_ready;
    logic       err_break;
    logic       err_framing;
    logic       err_parity;
    logic       err_overrun;
    logic [1:0] discard;
  } req_t;

  // One result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [8:0]  pending_count;
    logic        tx_irq_enable;
    logic        flow_stopped;
    logic [1:0]  discard_reads;
    logic [31:0] overrun_count;
    logic [31:0] parity_count;
    logic [31:0] framing_count;
    logic [31:0] break_count;
  } rsp_t;

endpackage

### design/scfe_ram.sv
module scfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/scfe_front.sv
module scfe_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           command,
  input  logic [7:0]           data_byte,
  input  logic [7:0]           line_status,
  input  logic                 tx_ready,
  output logic                 req_valid,
  output scfe_pkg::req_t       req,
  input  logic                 req_take
);

  scfe_pkg::req_t q [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     cnt;
  scfe_pkg::req_t cls;
  logic           do_push;
  logic           do_pop;
  logic           data_rdy;

  // Classify the incoming request
  always_comb begin
    data_rdy        = (line_status & scfe_pkg::LS_DATA) != 8'd0;
    cls.cmd         = command;
    cls.data        = data_byte;
    cls.is_xoff     = data_byte == scfe_pkg::CODE_XOFF;
    cls.is_xon      = data_byte == scfe_pkg::CODE_XON;
    cls.tx_ready    = tx_ready;
    cls.err_break   = (line_status & scfe_pkg::LS_BREAK) != 8'd0;
    cls.err_framing = (line_status & scfe_pkg::LS_FRAMING) != 8'd0;
    cls.err_parity  = (line_status & scfe_pkg::LS_PARITY) != 8'd0;
    cls.err_overrun = (line_status & scfe_pkg::LS_OVERRUN) != 8'd0;
    // discards only for break, framing, parity with data ready
    cls.discard     = data_rdy ? (2'({1'b0, cls.err_break}) + 2'({1'b0, cls.err_framing})
                                  + 2'({1'b0, cls.err_parity})) : 2'd0;
  end

  assign full      = cnt == 2'd2;
  assign do_push   = push && !full;
  assign req_valid = cnt != 2'd0;
  assign do_pop    = req_take && req_valid;
  assign req       = q[rd_ptr];

  // Request queue payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= cls;
    end
  end

  // Request queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

### design/scfe_back.sv
module scfe_back #(
  parameter int RING_DEPTH = scfe_pkg::RING_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  scfe_pkg::req_t req,
  output logic           req_take,
  output logic           rsp_empty,
  output scfe_pkg::rsp_t rsp,
  input  logic           rsp_pop
);

  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int FILL_W = $clog2(RING_DEPTH + 1);

  localparam logic S_RUN  = 1'b0;
  localparam logic S_SEND = 1'b1;

  logic              state, state_next;
  logic [PTR_W-1:0]  wp, wp_next;
  logic [PTR_W-1:0]  rp, rp_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic              hold, hold_next;
  logic              armed, armed_next;
  logic              irq, irq_next;
  logic [31:0]       ovr, ovr_next;
  logic [31:0]       par, par_next;
  logic [31:0]       frm, frm_next;
  logic [31:0]       brk, brk_next;

  logic              ram_we;
  logic [7:0]        ram_rdata;

  scfe_pkg::rsp_t    res;
  logic              res_push;
  logic              hold_eff;
  logic              can_send;

  scfe_pkg::rsp_t    oq [2];
  logic              oq_wr;
  logic              oq_rd;
  logic [1:0]        oq_cnt;
  logic              oq_full;
  logic              oq_pop;

  // Transmit ring storage
  scfe_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (req.data),
    .raddr (rp),
    .rdata (ram_rdata)
  );

  assign oq_full = oq_cnt == 2'd2;

  // Execute one request
  always_comb begin
    state_next = state;
    wp_next    = wp;
    rp_next    = rp;
    fill_next  = fill;
    hold_next  = hold;
    armed_next = armed;
    irq_next   = irq;
    ovr_next   = ovr;
    par_next   = par;
    frm_next   = frm;
    brk_next   = brk;
    ram_we     = 1'b0;
    req_take   = 1'b0;
    res_push   = 1'b0;
    hold_eff   = hold;
    can_send   = 1'b0;
    res.kind     = scfe_pkg::KIND_NONE;
    res.out_byte = 8'd0;
    res.discard_reads = 2'd0;

    if (state == S_SEND) begin
      // ring byte arrives from the registered read
      res_push     = 1'b1;
      res.kind     = scfe_pkg::KIND_TX;
      res.out_byte = ram_rdata;
      state_next   = S_RUN;
    end else if (req_valid && !oq_full) begin
      req_take = 1'b1;
      res_push = 1'b1;
      unique case (req.cmd)
        scfe_pkg::CMD_ENQ: begin
          if (fill == FILL_W'(RING_DEPTH)) begin
            res.kind     = scfe_pkg::KIND_TX;
            res.out_byte = req.data;
          end else begin
            ram_we    = 1'b1;
            wp_next   = (wp == PTR_W'(RING_DEPTH - 1)) ? '0 : wp + PTR_W'(1);
            fill_next = fill + FILL_W'(1);
            irq_next  = 1'b1;
          end
        end
        scfe_pkg::CMD_TXRDY: begin
          can_send = 1'b1;
        end
        scfe_pkg::CMD_RX: begin
          if (armed) begin
            armed_next   = 1'b0;
            res.kind     = scfe_pkg::KIND_SYSRQ;
            res.out_byte = req.data;
          end else if (req.is_xoff) begin
            hold_next = 1'b1;
          end else if (req.is_xon) begin
            hold_next = 1'b0;
            hold_eff  = 1'b0;
            can_send  = req.tx_ready;
          end else begin
            res.kind     = scfe_pkg::KIND_CONSOLE;
            res.out_byte = req.data;
          end
        end
        scfe_pkg::CMD_LS: begin
          if (req.err_break) begin
            brk_next   = brk + 32'd1;
            armed_next = 1'b1;
          end
          if (req.err_framing) begin
            frm_next = frm + 32'd1;
          end
          if (req.err_parity) begin
            par_next = par + 32'd1;
          end
          if (req.err_overrun) begin
            ovr_next = ovr + 32'd1;
          end
          res.discard_reads = req.discard;
        end
        default: ;
      endcase

      // drain one byte, or clear the interrupt request when empty
      if ((req.cmd == scfe_pkg::CMD_TXRDY) || (req.cmd == scfe_pkg::CMD_RX && !armed
          && !req.is_xoff && req.is_xon)) begin
        if (can_send && !hold_eff && fill != '0) begin
          rp_next    = (rp == PTR_W'(RING_DEPTH - 1)) ? '0 : rp + PTR_W'(1);
          fill_next  = fill - FILL_W'(1);
          res_push   = 1'b0;
          state_next = S_SEND;
          if (fill == FILL_W'(1)) begin
            irq_next = 1'b0;
          end
        end else if (fill == '0) begin
          irq_next = 1'b0;
        end
      end
    end

    res.pending_count = 9'(fill_next);
    res.tx_irq_enable = irq_next;
    res.flow_stopped  = hold_next;
    res.overrun_count = ovr_next;
    res.parity_count  = par_next;
    res.framing_count = frm_next;
    res.break_count   = brk_next;
  end

  // Engine state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
      wp    <= '0;
      rp    <= '0;
      fill  <= '0;
      hold  <= 1'b0;
      armed <= 1'b0;
      irq   <= 1'b0;
      ovr   <= 32'd0;
      par   <= 32'd0;
      frm   <= 32'd0;
      brk   <= 32'd0;
    end else begin
      state <= state_next;
      wp    <= wp_next;
      rp    <= rp_next;
      fill  <= fill_next;
      hold  <= hold_next;
      armed <= armed_next;
      irq   <= irq_next;
      ovr   <= ovr_next;
      par   <= par_next;
      frm   <= frm_next;
      brk   <= brk_next;
    end
  end

  // Result queue
  assign rsp_empty = oq_cnt == 2'd0;
  assign oq_pop    = rsp_pop && !rsp_empty;
  assign rsp       = oq[oq_rd];

  always_ff @(posedge clk) begin
    if (res_push) begin
      oq[oq_wr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr  <= 1'b0;
      oq_rd  <= 1'b0;
      oq_cnt <= 2'd0;
    end else begin
      if (res_push) begin
        oq_wr <= ~oq_wr;
      end
      if (oq_pop) begin
        oq_rd <= ~oq_rd;
      end
      if (res_push && !oq_pop) begin
        oq_cnt <= oq_cnt + 2'd1;
      end else if (oq_pop && !res_push) begin
        oq_cnt <= oq_cnt - 2'd1;
      end
    end
  end

endmodule

### design/serial_console_flow_engine.sv
// A request pushed into the front queue is taken from it by the back end and its result is
// registered in the result queue, where empty goes low; a ring drain first goes through
// the RAM read and the send state. One request per cycle, stalled by a full queue or a send.
// Reset: synchronous rst clears pointers, fill level, flags, error counters and both
// queues; ring contents stay undefined until written, with no clearing pass.
module serial_console_flow_engine #(
  parameter int RING_DEPTH = scfe_pkg::RING_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  command,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  line_status,
  input  logic        tx_ready,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [7:0]  out_byte,
  output logic [8:0]  pending_count,
  output logic        tx_irq_enable,
  output logic        flow_stopped,
  output logic [1:0]  discard_reads,
  output logic [31:0] overrun_count,
  output logic [31:0] parity_count,
  output logic [31:0] framing_count,
  output logic [31:0] break_count
);

  logic           req_valid;
  logic           req_take;
  scfe_pkg::req_t req;
  scfe_pkg::rsp_t rsp;

  // Front: accept and classify
  scfe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .command     (command),
    .data_byte   (data_byte),
    .line_status (line_status),
    .tx_ready    (tx_ready),
    .req_valid   (req_valid),
    .req         (req),
    .req_take    (req_take)
  );

  // Back: ring, flow control, counters
  scfe_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_take  (req_take),
    .rsp_empty (empty),
    .rsp       (rsp),
    .rsp_pop   (pop)
  );

  assign kind          = rsp.kind;
  assign out_byte      = rsp.out_byte;
  assign pending_count = rsp.pending_count;
  assign tx_irq_enable = rsp.tx_irq_enable;
  assign flow_stopped  = rsp.flow_stopped;
  assign discard_reads = rsp.discard_reads;
  assign overrun_count = rsp.overrun_count;
  assign parity_count  = rsp.parity_count;
  assign framing_count = rsp.framing_count;
  assign break_count   = rsp.break_count;

endmodule
